/* hw/rtl/cursor_array_sequence_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cursor array sequence block
// Shared shorthand for clocked concurrent assertions with reset masking.
// ----------------------------------------------------------------------------
`ifndef CURSOR_ARRAY_SEQUENCE_TOP_ASSERT_SVH
`define CURSOR_ARRAY_SEQUENCE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cas_pkg.sv */
// ----------------------------------------------------------------------------
// cas_pkg
// Opcodes, error codes and fixed field widths of the cursor array sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cas_pkg;

  localparam int OPCODE_W = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int ERR_W    = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_READ_CUR   = 4'd0,
    OP_START      = 4'd1,
    OP_END        = 4'd2,
    OP_LAST_SLOT  = 4'd3,
    OP_ADVANCE    = 4'd4,
    OP_RETREAT    = 4'd5,
    OP_INSERT     = 4'd6,
    OP_ATTACH     = 4'd7,
    OP_REMOVE_CUR = 4'd8,
    OP_INS_FRONT  = 4'd9,
    OP_APPEND     = 4'd10,
    OP_REM_FRONT  = 4'd11,
    OP_READ_IDX   = 4'd12
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK      = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_NO_ITEM = 2'd2,
    ERR_RANGE   = 2'd3
  } err_t;

endpackage

/* hw/rtl/cas_ram.sv */
// ----------------------------------------------------------------------------
// cas_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/cursor_array_sequence_top.sv */
// ----------------------------------------------------------------------------
// cursor_array_sequence_top
// An ordered list of up to CAPACITY_ENTRIES data words held in one RAM, with
// a cursor, driven by one opcode per input transaction and answering with
// exactly one result transaction. Cursor moves go straight to the done
// state; reads of the current or an indexed entry first pass the read
// state, which registers the RAM word. An insert, attach or append moves
// the entries behind the affected place one slot through the single RAM
// read port and single write port, one entry per cycle, and then writes
// the new word in the fill state; a removal only moves entries. The input
// stalls while a transaction is in work; a finished result sits in an
// output register, so the next transaction may start while it waits. The
// RAM is not cleared after reset; only entries below the count are ever
// read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_array_sequence_top
  import cas_pkg::*;
#(
  parameter int CAPACITY_ENTRIES = 64,
  parameter int DATA_WIDTH       = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [VALUE_W-1:0]  in_entry_value,
  input  logic [POS_W-1:0]    in_read_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VALUE_W-1:0]  out_read_value,
  output logic                out_has_current,
  output logic [COUNT_W-1:0]  out_item_count,
  output logic [COUNT_W-1:0]  out_cursor_position,
  output logic [ERR_W-1:0]    out_error_code
);

  localparam int AW = $clog2(CAPACITY_ENTRIES);
  localparam int CW = $clog2(CAPACITY_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_FILL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic          pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  err_t            err_r, err_nxt;
  logic [DATA_WIDTH-1:0] rdv_r, rdv_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]   fill_addr_r, fill_addr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]   wa_r, wa_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic            dir_up_r, dir_up_nxt;
  logic            fill_r, fill_nxt;

  logic [VALUE_W-1:0] out_read_value_r;
  logic               out_has_current_r;
  logic [COUNT_W-1:0] out_item_count_r;
  logic [COUNT_W-1:0] out_cursor_position_r;
  err_t               out_error_code_r;
  logic               out_load;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic          accept;
  logic          cur;
  logic          full;
  logic          pos_ok;
  logic [CW-1:0] ins_pos;
  logic [CW-1:0] cur_p1;
  op_t           op;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign op       = op_t'(in_opcode);
  assign cur      = (cursor_r < count_r);
  assign full     = (count_r >= CW'(CAPACITY_ENTRIES));
  assign pos_ok   = (32'(in_read_position) < 32'(count_r));
  assign ins_pos  = ((op == OP_INS_FRONT) || !cur) ? '0 : cursor_r;
  assign cur_p1   = cursor_r + CW'(1);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    pend_nxt      = pend_r;
    err_nxt       = err_r;
    rdv_nxt       = rdv_r;
    val_nxt       = val_r;
    fill_addr_nxt = fill_addr_r;
    rd_ptr_nxt    = rd_ptr_r;
    wa_nxt        = wa_r;
    rem_nxt       = rem_r;
    dir_up_nxt    = dir_up_r;
    fill_nxt      = fill_r;
    mem_we        = 1'b0;
    mem_waddr     = wa_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = rd_ptr_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          err_nxt   = ERR_OK;
          rdv_nxt   = '0;
          val_nxt   = DATA_WIDTH'(in_entry_value);
          pend_nxt  = 1'b0;
          rem_nxt   = '0;
          fill_nxt  = 1'b0;
          state_nxt = S_DONE;
          case (op)
            OP_READ_CUR: begin
              if (cur) begin
                mem_raddr = AW'(cursor_r);
                state_nxt = S_READ;
              end else begin
                err_nxt = ERR_NO_ITEM;
              end
            end
            OP_START: begin
              cursor_nxt = '0;
            end
            OP_END: begin
              if (count_r == '0) begin
                cursor_nxt = '0;
                err_nxt    = ERR_NO_ITEM;
              end else begin
                cursor_nxt = count_r - CW'(1);
              end
            end
            OP_LAST_SLOT: begin
              cursor_nxt = CW'(CAPACITY_ENTRIES - 1);
            end
            OP_ADVANCE: begin
              if (cur) begin
                cursor_nxt = cur_p1;
              end else begin
                err_nxt = ERR_NO_ITEM;
              end
            end
            OP_RETREAT: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - CW'(1);
              end
            end
            OP_INSERT, OP_INS_FRONT: begin
              if (full) begin
                err_nxt = ERR_FULL;
              end else begin
                cursor_nxt    = ins_pos;
                count_nxt     = count_r + CW'(1);
                rem_nxt       = count_r - ins_pos;
                rd_ptr_nxt    = AW'(count_r - CW'(1));
                dir_up_nxt    = 1'b1;
                fill_nxt      = 1'b1;
                fill_addr_nxt = AW'(ins_pos);
                state_nxt     = S_SHIFT;
              end
            end
            OP_ATTACH: begin
              if (full) begin
                err_nxt = ERR_FULL;
              end else begin
                count_nxt  = count_r + CW'(1);
                dir_up_nxt = 1'b1;
                fill_nxt   = 1'b1;
                state_nxt  = S_SHIFT;
                rd_ptr_nxt = AW'(count_r - CW'(1));
                if (cur) begin
                  cursor_nxt    = cur_p1;
                  rem_nxt       = count_r - cur_p1;
                  fill_addr_nxt = AW'(cur_p1);
                end else begin
                  cursor_nxt    = count_r;
                  fill_addr_nxt = AW'(count_r);
                end
              end
            end
            OP_REMOVE_CUR: begin
              if (!cur) begin
                err_nxt = ERR_NO_ITEM;
              end else begin
                count_nxt  = count_r - CW'(1);
                rem_nxt    = count_r - cur_p1;
                rd_ptr_nxt = AW'(cur_p1);
                dir_up_nxt = 1'b0;
                state_nxt  = S_SHIFT;
              end
            end
            OP_APPEND: begin
              if (full) begin
                err_nxt = ERR_FULL;
              end else begin
                cursor_nxt    = count_r;
                count_nxt     = count_r + CW'(1);
                fill_nxt      = 1'b1;
                fill_addr_nxt = AW'(count_r);
                state_nxt     = S_SHIFT;
              end
            end
            OP_REM_FRONT: begin
              if (!cur) begin
                err_nxt = ERR_NO_ITEM;
              end else begin
                cursor_nxt = '0;
                count_nxt  = count_r - CW'(1);
                rem_nxt    = count_r - CW'(1);
                rd_ptr_nxt = AW'(1);
                dir_up_nxt = 1'b0;
                state_nxt  = S_SHIFT;
              end
            end
            OP_READ_IDX: begin
              if (pos_ok) begin
                mem_raddr = AW'(in_read_position);
                state_nxt = S_READ;
              end else begin
                err_nxt = ERR_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        rdv_nxt   = mem_rdata;
        state_nxt = S_DONE;
      end
      S_SHIFT: begin
        // The word read in the previous cycle lands one slot over now,
        // while the next read is issued, so one entry moves per cycle.
        mem_we = pend_r;
        if (rem_r != '0) begin
          mem_raddr  = rd_ptr_r;
          wa_nxt     = dir_up_r ? (rd_ptr_r + AW'(1)) : (rd_ptr_r - AW'(1));
          rd_ptr_nxt = dir_up_r ? (rd_ptr_r - AW'(1)) : (rd_ptr_r + AW'(1));
          rem_nxt    = rem_r - CW'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = fill_r ? S_FILL : S_DONE;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr_r;
        mem_wdata = val_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r       <= err_nxt;
    rdv_r       <= rdv_nxt;
    val_r       <= val_nxt;
    fill_addr_r <= fill_addr_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    wa_r        <= wa_nxt;
    rem_r       <= rem_nxt;
    dir_up_r    <= dir_up_nxt;
    fill_r      <= fill_nxt;
    if (out_load) begin
      out_read_value_r      <= VALUE_W'(rdv_r);
      out_has_current_r     <= (cursor_r < count_r);
      out_item_count_r      <= COUNT_W'(count_r);
      out_cursor_position_r <= COUNT_W'(cursor_r);
      out_error_code_r      <= err_r;
    end
  end

  cas_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_read_value      = out_read_value_r;
  assign out_has_current     = out_has_current_r;
  assign out_item_count      = out_item_count_r;
  assign out_cursor_position = out_cursor_position_r;
  assign out_error_code      = out_error_code_r;

endmodule

/* hw/rtl/cas_checker.sv */
// ----------------------------------------------------------------------------
// cas_checker
// Port-level checks of the cursor array sequence block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cursor_array_sequence_top_assert.svh"

module cas_checker
  import cas_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [VALUE_W-1:0]  out_read_value,
  input logic                out_has_current,
  input logic [COUNT_W-1:0]  out_item_count,
  input logic [COUNT_W-1:0]  out_cursor_position,
  input logic [ERR_W-1:0]    out_error_code
);

  // A held result must not change under stall.
  `CAS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_value) && $stable(out_has_current) && $stable(out_item_count) && $stable(out_cursor_position) && $stable(out_error_code), "result changed while stalled")

  // Every accepted transaction leaves the block busy, so the input is never taken twice in a row.
  `CAS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken twice in a row")

  // A new result only appears once the block has been busy with work.
  `CAS_ASSERT_SAME(a_result_after_work, $rose(out_valid), $past(in_stall), "result without work")

  // A refused operation never returns data.
  `CAS_ASSERT_SAME(a_err_no_data, out_valid && (out_error_code != ERR_OK), out_read_value == '0, "data returned with an error")

endmodule

bind cursor_array_sequence_top cas_checker u_cas_checker (.*);
